// File: hdl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_READY_TIMEOUT = 2'd0,
    REG_ECHO_TIMEOUT  = 2'd1,
    REG_TRIG_SETTLE   = 2'd2,
    REG_TRIG_HIGH     = 2'd3
  } reg_idx_t;

  localparam logic [15:0] READY_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
  localparam logic [7:0]  TRIG_SETTLE_RST   = 8'd2;
  localparam logic [7:0]  TRIG_HIGH_RST     = 8'd10;

  // Status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_SUCCESS    = 3'd1;
  localparam logic [2:0] ST_STUCK_HIGH = 3'd2;
  localparam logic [2:0] ST_NO_ECHO    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  // floor(x / 58) = (x * 36158) >> 21 for every 16-bit x
  localparam logic [15:0] DIV58_RECIP = 16'd36158;
  localparam int          DIV58_SHIFT = 21;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_WAIT_LOW  = 6'b000010,
    PH_SETTLE    = 6'b000100,
    PH_TRIG_HIGH = 6'b001000,
    PH_WAIT_HIGH = 6'b010000,
    PH_MEASURE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] ready_timeout_us;
    logic [15:0] echo_timeout_us;
    logic [7:0]  trigger_settle_us;
    logic [7:0]  trigger_high_us;
  } cfg_t;

  typedef struct packed {
    logic [10:0] distance_centimeters;
    logic [2:0]  status;
    logic        busy_res;
    logic        trigger_level;
  } result_t;

endpackage

// File: hdl/uer_regs.sv
`timescale 1ns / 1ps

module uer_regs import uer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_timeout_us  <= READY_TIMEOUT_RST;
      cfg.echo_timeout_us   <= ECHO_TIMEOUT_RST;
      cfg.trigger_settle_us <= TRIG_SETTLE_RST;
      cfg.trigger_high_us   <= TRIG_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_READY_TIMEOUT: cfg.ready_timeout_us  <= pwdata[15:0];
        REG_ECHO_TIMEOUT:  cfg.echo_timeout_us   <= pwdata[15:0];
        REG_TRIG_SETTLE:   cfg.trigger_settle_us <= pwdata[7:0];
        REG_TRIG_HIGH:     cfg.trigger_high_us   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_READY_TIMEOUT: prdata = {16'd0, cfg.ready_timeout_us};
      REG_ECHO_TIMEOUT:  prdata = {16'd0, cfg.echo_timeout_us};
      REG_TRIG_SETTLE:   prdata = {24'd0, cfg.trigger_settle_us};
      REG_TRIG_HIGH:     prdata = {24'd0, cfg.trigger_high_us};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// File: hdl/uer_core.sv
`timescale 1ns / 1ps

module uer_core import uer_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  cfg_t    cfg,
  input  logic    start_request,
  input  logic    echo_level,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] tick_inc;
  logic [31:0] div_prod;
  logic [2:0]  status;
  logic        take_dist;

  assign tick_inc = tick_count + 16'd1;
  assign div_prod = {16'd0, tick_count} * {16'd0, DIV58_RECIP};

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    status          = ST_NONE;
    take_dist       = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_request) begin
          phase_next      = PH_WAIT_LOW;
          tick_count_next = 16'd0;
        end
      end
      PH_WAIT_LOW: begin
        if (!echo_level) begin
          phase_next      = (cfg.trigger_settle_us == 8'd0) ? PH_TRIG_HIGH : PH_SETTLE;
          tick_count_next = 16'd1;
        end else if (tick_inc >= cfg.ready_timeout_us) begin
          phase_next      = PH_IDLE;
          tick_count_next = 16'd0;
          status          = ST_STUCK_HIGH;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_SETTLE: begin
        if (tick_count >= {8'd0, cfg.trigger_settle_us}) begin
          phase_next      = PH_TRIG_HIGH;
          tick_count_next = 16'd1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (tick_count >= {8'd0, cfg.trigger_high_us}) begin
          phase_next      = PH_WAIT_HIGH;
          tick_count_next = 16'd0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_WAIT_HIGH: begin
        if (echo_level) begin
          // first high sample counts as one tick of width
          if (cfg.echo_timeout_us == 16'd0) begin
            phase_next      = PH_IDLE;
            tick_count_next = 16'd0;
            status          = ST_TOO_LONG;
          end else begin
            phase_next      = PH_MEASURE;
            tick_count_next = 16'd1;
          end
        end else if (tick_inc >= cfg.echo_timeout_us) begin
          phase_next      = PH_IDLE;
          tick_count_next = 16'd0;
          status          = ST_NO_ECHO;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_MEASURE: begin
        if (!echo_level) begin
          phase_next      = PH_IDLE;
          tick_count_next = 16'd0;
          status          = ST_SUCCESS;
          take_dist       = 1'b1;
        end else if (tick_count >= cfg.echo_timeout_us) begin
          phase_next      = PH_IDLE;
          tick_count_next = 16'd0;
          status          = ST_TOO_LONG;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 16'd0;
      end
    endcase
  end

  always_comb begin
    res.trigger_level        = (phase_next == PH_TRIG_HIGH);
    res.busy_res             = (phase_next != PH_IDLE);
    res.status               = status;
    res.distance_centimeters = take_dist ? div_prod[DIV58_SHIFT +: 11] : 11'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic echo ranger: trigger/echo sequencer for an HC-SR04 style sensor.
// Input stream: one transfer per microsecond tick carrying the start request
// and the sampled echo level. Output stream: exactly one transfer per input
// transfer, giving the trigger pin level, busy flag, a status code (non-zero
// only on the tick a measurement ends) and the distance in cm (echo width / 58,
// non-zero only on success).
// Path: an input transfer lands in the input register and is stepped through
// the sequencer into the output register, whose contents drive the output.
// One transfer per cycle sustained while m_tready stays high; the only
// per-item work is one sequencer step plus a 16x16 reciprocal multiply, both
// combinational between the two registers.
// Stall: while the output register is full and m_tready is low, the input
// register holds its item and s_tready falls once it is occupied; nothing is
// dropped and the sequencer only advances when an item moves on.
// Reset (rst, synchronous): both registers empty, sequencer idle, timing
// registers back to 1000 / 30000 / 2 / 10. Registers are written over the APB
// port at 4*index; they should only be changed while the block is idle.

module ultrasonic_echo_ranger import uer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_request, [1] echo_level, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] trigger_level, [1] busy_res, [4:2] status,
                                 // [15:5] distance_centimeters
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    in_vld;
  logic    in_start;
  logic    in_echo;
  logic    step;

  uer_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // an item moves from the input register into the output register
  assign step     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_start <= s_tdata[0];
      in_echo  <= s_tdata[1];
    end
  end

  uer_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cfg           (cfg),
    .start_request (in_start),
    .echo_level    (in_echo),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res;

endmodule
